// File: hw/rtl/les_pkg.sv
// Shared types, constants and effect codes of the LED effect sequencer.
package les_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int LVL_W         = 8;
  localparam int EFF_W         = 4;

  localparam logic [EFF_W-1:0] EFF_DIRECT       = 4'd0;
  localparam logic [EFF_W-1:0] EFF_FADE         = 4'd1;
  localparam logic [EFF_W-1:0] EFF_STROBE       = 4'd2;
  localparam logic [EFF_W-1:0] EFF_SET_FADE     = 4'd3;
  localparam logic [EFF_W-1:0] EFF_LIGHTNING    = 4'd4;
  localparam logic [EFF_W-1:0] EFF_LT_DISAPPEAR = 4'd5;
  localparam logic [EFF_W-1:0] EFF_LT_APPEAR    = 4'd6;
  localparam logic [EFF_W-1:0] EFF_MACHINE_GUN  = 4'd7;
  localparam logic [EFF_W-1:0] EFF_ACCEL_STROBE = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_DIV,
    ST_APPLY
  } les_state_t;

  // load a new operand set, or advance one bit
  typedef struct packed {
    logic load;
    logic step;
  } les_ser_ctl_t;

endpackage

// File: hw/rtl/les_in_if.sv
// Input channel interface: tick or command items.
interface les_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [les_pkg::NOW_W-1:0]   now_ms;
  logic [les_pkg::EFF_W-1:0]   effect;
  logic [les_pkg::LVL_W-1:0]   level_a;
  logic [les_pkg::LVL_W-1:0]   level_b;
  logic [les_pkg::LVL_W-1:0]   step_ms;
  logic [les_pkg::LVL_W-1:0]   aux_a;
  logic [les_pkg::LVL_W-1:0]   aux_b;

  modport source (output valid, mode, now_ms, effect, level_a, level_b, step_ms,
                  aux_a, aux_b, input ready);
  modport sink   (input valid, mode, now_ms, effect, level_a, level_b, step_ms,
                  aux_a, aux_b, output ready);
endinterface

// File: hw/rtl/les_out_if.sv
// Result channel interface: brightness and status items.
interface les_out_if;
  logic                      valid;
  logic                      ready;
  logic [les_pkg::LVL_W-1:0] brightness;
  logic                      level_written;
  logic                      busy_res;

  modport source (output valid, brightness, level_written, busy_res, input ready);
  modport sink   (input valid, brightness, level_written, busy_res, output ready);
endinterface

// File: hw/rtl/led_effect_sequencer_unit.sv
// Top level of the LED effect sequencer: control, effect state and result register.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | mode, now_ms, effect, level_a/b, step_ms, aux_a/b
//  out_ch  | out | valid / ready    | brightness, level_written, busy_res
//
// A command, or a tick while level equals target, goes from accept straight to update
// and output. Any other tick first runs the bit-serial elapsed-time subtract, then
// loads the divider and runs the bit-serial step-count divide, then update and output.
// Reset (rst_n low, synchronous) clears all effect state to zero and empties the output.
// A result waits in the output register while out_ch.ready is low; the next item is
// taken meanwhile, but its update holds until that register is free.
module led_effect_sequencer_unit #(
  parameter int TIME_BITS = les_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  les_in_if.sink     in_ch,
  les_out_if.source  out_ch
);

  localparam int LW    = les_pkg::LVL_W;
  localparam int EW    = les_pkg::EFF_W;
  localparam int CNT_W = $clog2(TIME_BITS + 1);

  les_pkg::les_state_t  state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // held item
  logic                 mode_r;
  logic [TIME_BITS-1:0] now_r;
  logic [EW-1:0]        eff_in_r;
  logic [LW-1:0]        a_r, b_r, st_r, xa_r, xb_r;
  logic                 tick_run_r, tick_run_nxt;

  // effect state
  logic [LW-1:0]        level_r, level_nxt;
  logic [LW-1:0]        target_r, target_nxt;
  logic [LW-1:0]        step_r, step_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [EW-1:0]        kind_r, kind_nxt;
  logic [LW-1:0]        aux1_r, aux1_nxt;
  logic [LW-1:0]        aux2_r, aux2_nxt;
  logic [LW-1:0]        aux3_r, aux3_nxt;
  logic                 wrote;

  // result register
  logic                 out_valid_r;
  logic [LW-1:0]        out_bright_r;
  logic                 out_wrote_r;
  logic                 out_busy_r;

  les_pkg::les_ser_ctl_t sub_ctl, div_ctl;
  logic [TIME_BITS-1:0]  passed;
  logic [LW-1:0]         quot;
  logic                  quot_ovf;
  logic                  in_acc;
  logic                  commit;
  logic                  passed_ok;
  logic [LW-1:0]         lvl_gap;
  logic                  reach;

  // the subtractor takes the time straight off the channel at the accepting edge
  les_serial_sub #(.TIME_BITS(TIME_BITS)) u_sub (
    .clk        (clk),
    .ctl        (sub_ctl),
    .minuend    (TIME_BITS'(in_ch.now_ms)),
    .subtrahend (last_r),
    .diff       (passed)
  );

  les_serial_div #(.TIME_BITS(TIME_BITS)) u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (passed),
    .divisor  (step_r),
    .quot     (quot),
    .quot_ovf (quot_ovf)
  );

  assign in_ch.ready = (state_r == les_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == les_pkg::ST_APPLY) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    tick_run_nxt = tick_run_r;
    sub_ctl      = '0;
    div_ctl      = '0;
    case (state_r)
      les_pkg::ST_IDLE: begin
        if (in_acc) begin
          sub_ctl.load = 1'b1;
          cnt_nxt      = '0;
          if (!in_ch.mode && (level_r != target_r)) begin
            tick_run_nxt = 1'b1;
            state_nxt    = les_pkg::ST_SUB;
          end else begin
            tick_run_nxt = 1'b0;
            state_nxt    = les_pkg::ST_APPLY;
          end
        end
      end
      les_pkg::ST_SUB: begin
        sub_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TIME_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = les_pkg::ST_DIV;
        end
      end
      les_pkg::ST_DIV: begin
        // load the elapsed time first, then shift out one quotient bit a cycle
        if (cnt_r == '0) begin
          div_ctl.load = 1'b1;
        end else begin
          div_ctl.step = 1'b1;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TIME_BITS)) begin
          cnt_nxt   = '0;
          state_nxt = les_pkg::ST_APPLY;
        end
      end
      les_pkg::ST_APPLY: begin
        if (commit) begin
          state_nxt = les_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = les_pkg::ST_IDLE;
      end
    endcase
  end

  // effect update
  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    step_nxt   = step_r;
    last_nxt   = last_r;
    kind_nxt   = kind_r;
    aux1_nxt   = aux1_r;
    aux2_nxt   = aux2_r;
    aux3_nxt   = aux3_r;
    wrote      = 1'b0;
    passed_ok  = quot_ovf || (quot != '0);
    lvl_gap    = (level_r < target_r) ? (target_r - level_r) : (level_r - target_r);
    reach      = quot_ovf || (quot >= lvl_gap);

    if (mode_r) begin
      kind_nxt = eff_in_r;
      case (eff_in_r)
        les_pkg::EFF_DIRECT: begin
          level_nxt  = a_r;
          wrote      = 1'b1;
          target_nxt = a_r;
        end
        les_pkg::EFF_FADE: begin
          if (st_r == '0) begin
            level_nxt = a_r;
            wrote     = 1'b1;
          end else begin
            step_nxt = st_r;
          end
          target_nxt = a_r;
          aux1_nxt   = '0;
        end
        les_pkg::EFF_STROBE: begin
          wrote = 1'b1;
          if (level_r == a_r) begin
            level_nxt  = '0;
            target_nxt = a_r;
          end else begin
            level_nxt  = a_r;
            target_nxt = '0;
          end
          step_nxt = st_r;
        end
        les_pkg::EFF_SET_FADE: begin
          wrote = 1'b1;
          if (st_r == '0) begin
            level_nxt = b_r;
          end else begin
            level_nxt = a_r;
            step_nxt  = st_r;
          end
          target_nxt = b_r;
          kind_nxt   = les_pkg::EFF_FADE;
        end
        les_pkg::EFF_LIGHTNING: begin
          wrote      = 1'b1;
          level_nxt  = a_r;
          step_nxt   = st_r;
          target_nxt = '0;
        end
        les_pkg::EFF_LT_DISAPPEAR: begin
          wrote      = 1'b1;
          level_nxt  = a_r;
          step_nxt   = xa_r;
          aux1_nxt   = st_r;
          target_nxt = b_r;
        end
        les_pkg::EFF_LT_APPEAR: begin
          wrote      = 1'b1;
          level_nxt  = a_r;
          step_nxt   = st_r;
          aux1_nxt   = xa_r;
          target_nxt = b_r;
          kind_nxt   = les_pkg::EFF_FADE;
        end
        les_pkg::EFF_MACHINE_GUN: begin
          wrote = 1'b1;
          if (level_r == a_r) begin
            level_nxt  = '0;
            target_nxt = a_r;
            aux1_nxt   = b_r;
          end else begin
            level_nxt  = a_r;
            target_nxt = '0;
            aux1_nxt   = b_r - LW'(1);
          end
          step_nxt = st_r;
        end
        les_pkg::EFF_ACCEL_STROBE: begin
          wrote      = 1'b1;
          level_nxt  = a_r;
          target_nxt = '0;
          step_nxt   = st_r;
          aux1_nxt   = xa_r;
          aux2_nxt   = xb_r;
        end
        default: begin
        end
      endcase
      if (wrote || (eff_in_r == les_pkg::EFF_FADE)) begin
        last_nxt = now_r;
      end
    end else if (tick_run_r && passed_ok) begin
      case (kind_r)
        les_pkg::EFF_FADE: begin
          wrote = 1'b1;
          if (level_r < target_r) begin
            if (reach) begin
              level_nxt = target_r;
              if (aux1_r != '0) begin
                step_nxt   = aux1_r;
                target_nxt = '0;
                kind_nxt   = les_pkg::EFF_LIGHTNING;
              end
            end else begin
              level_nxt = level_r + quot;
            end
          end else begin
            level_nxt = reach ? target_r : (level_r - quot);
          end
        end
        les_pkg::EFF_STROBE: begin
          wrote = 1'b1;
          if (level_r == '0) begin
            level_nxt  = target_r;
            target_nxt = '0;
          end else begin
            target_nxt = level_r;
            level_nxt  = '0;
          end
        end
        les_pkg::EFF_LIGHTNING: begin
          wrote     = 1'b1;
          level_nxt = target_r;
        end
        les_pkg::EFF_LT_DISAPPEAR: begin
          step_nxt = aux1_r;
          aux1_nxt = '0;
          kind_nxt = les_pkg::EFF_FADE;
        end
        les_pkg::EFF_MACHINE_GUN: begin
          wrote = 1'b1;
          if (level_r == '0) begin
            level_nxt  = target_r;
            target_nxt = '0;
            aux1_nxt   = aux1_r - LW'(1);
          end else begin
            level_nxt  = '0;
            target_nxt = (aux1_r == '0) ? '0 : level_r;
          end
        end
        les_pkg::EFF_ACCEL_STROBE: begin
          wrote = 1'b1;
          if (level_r == '0) begin
            level_nxt = target_r;
            if (aux1_r != '0) begin
              target_nxt = '0;
              step_nxt   = aux3_r;
            end
          end else begin
            target_nxt = level_r;
            level_nxt  = '0;
            aux3_nxt   = step_r;
            step_nxt   = aux1_r;
            aux1_nxt   = (aux1_r > aux2_r) ? (aux1_r - aux2_r) : '0;
          end
        end
        default: begin
        end
      endcase
      if (wrote || (kind_r == les_pkg::EFF_LT_DISAPPEAR)) begin
        last_nxt = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= les_pkg::ST_IDLE;
      cnt_r      <= '0;
      tick_run_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      tick_run_r <= tick_run_nxt;
    end
  end

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_ch.mode;
      now_r    <= TIME_BITS'(in_ch.now_ms);
      eff_in_r <= in_ch.effect;
      a_r      <= in_ch.level_a;
      b_r      <= in_ch.level_b;
      st_r     <= in_ch.step_ms;
      xa_r     <= in_ch.aux_a;
      xb_r     <= in_ch.aux_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      step_r   <= '0;
      last_r   <= '0;
      kind_r   <= les_pkg::EFF_DIRECT;
      aux1_r   <= '0;
      aux2_r   <= '0;
      aux3_r   <= '0;
    end else if (commit) begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      step_r   <= step_nxt;
      last_r   <= last_nxt;
      kind_r   <= kind_nxt;
      aux1_r   <= aux1_nxt;
      aux2_r   <= aux2_nxt;
      aux3_r   <= aux3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_bright_r <= level_nxt;
      out_wrote_r  <= wrote;
      out_busy_r   <= (level_nxt != target_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.brightness    = out_bright_r;
  assign out_ch.level_written = out_wrote_r;
  assign out_ch.busy_res      = out_busy_r;

endmodule

// File: hw/rtl/les_serial_sub.sv
// Bit-serial subtractor: elapsed time, least significant bit first.
module les_serial_sub #(
  parameter int TIME_BITS = les_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  les_pkg::les_ser_ctl_t ctl,
  input  logic [TIME_BITS-1:0]  minuend,
  input  logic [TIME_BITS-1:0]  subtrahend,
  output logic [TIME_BITS-1:0]  diff
);

  logic [TIME_BITS-1:0] a_sh_r;
  logic [TIME_BITS-1:0] b_sh_r;
  logic [TIME_BITS-1:0] diff_r;
  logic                 borrow_r;
  logic                 dbit;
  logic                 borrow_nxt;

  always_comb begin
    dbit       = a_sh_r[0] ^ b_sh_r[0] ^ borrow_r;
    borrow_nxt = (~a_sh_r[0] & b_sh_r[0]) | (~(a_sh_r[0] ^ b_sh_r[0]) & borrow_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_sh_r   <= minuend;
      b_sh_r   <= subtrahend;
      borrow_r <= 1'b0;
    end else if (ctl.step) begin
      a_sh_r   <= a_sh_r >> 1;
      b_sh_r   <= b_sh_r >> 1;
      borrow_r <= borrow_nxt;
      diff_r   <= {dbit, diff_r[TIME_BITS-1:1]};
    end
  end

  assign diff = diff_r;

endmodule

// File: hw/rtl/les_serial_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient with an overflow flag.
module les_serial_div #(
  parameter int TIME_BITS = les_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  les_pkg::les_ser_ctl_t       ctl,
  input  logic [TIME_BITS-1:0]        dividend,
  input  logic [les_pkg::LVL_W-1:0]   divisor,
  output logic [les_pkg::LVL_W-1:0]   quot,
  output logic                        quot_ovf
);

  localparam int LW = les_pkg::LVL_W;

  logic [TIME_BITS-1:0] dvd_r;
  logic [LW-1:0]        dvs_r;
  logic [LW-1:0]        rem_r;
  logic [LW-1:0]        q_r;
  logic                 ovf_r;
  logic [LW:0]          trial;
  logic [LW:0]          trial_sub;
  logic                 fits;

  always_comb begin
    trial     = {rem_r, dvd_r[TIME_BITS-1]};
    trial_sub = trial - {1'b0, dvs_r};
    fits      = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (ctl.step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= fits ? trial_sub[LW-1:0] : trial[LW-1:0];
      q_r   <= {q_r[LW-2:0], fits};
      // any bit pushed out of the top makes the count huge
      ovf_r <= ovf_r | q_r[LW-1];
    end
  end

  assign quot     = q_r;
  assign quot_ovf = ovf_r;

endmodule
